[sv/vector_map_through_portal_pair_macros.svh]
// Assertion helpers for the checker of this block.
// Both sample on clk and are off while rst_n is low.
`ifndef VECTOR_MAP_THROUGH_PORTAL_PAIR_MACROS_SVH
`define VECTOR_MAP_THROUGH_PORTAL_PAIR_MACROS_SVH

// same-cycle implication
`define VMPP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VMPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/vmpp_pkg.sv]
package vmpp_pkg;

  localparam int VW    = 32;  // vector component
  localparam int CW    = 16;  // normal component, Q2.14
  localparam int DOTW  = 36;  // rounded v.n1
  localparam int TW    = 52;  // dot * n
  localparam int FW    = 39;  // reflected vector
  localparam int KW    = 19;  // rotation axis k, Q.14
  localparam int PFW   = 58;  // k * f product
  localparam int AW    = 43;  // k x f
  localparam int PAW   = 62;  // k * a product
  localparam int BW    = 47;  // k x (k x f)
  localparam int DW    = 29;  // divisor 2^28 + c
  localparam int QW    = 56;  // quotient bits
  localparam int NUMW  = 74;  // dividend |b| * 2^28 + d/2
  localparam int BASEW = 44;  // f + a
  localparam int SUMW  = 58;  // final sum before saturation
  localparam int CSW   = 34;  // cosine, Q.28

  localparam logic signed [CSW-1:0] COS_LIMIT  = 34'sd268167021;
  localparam logic signed [CW-1:0]  AXIS_LIMIT = 16'sd14746;
  localparam logic signed [CSW-1:0] ONE_Q28    = 34'sd268435456;

  typedef enum logic [2:0] {
    REG_ENTRY_X = 3'd0,
    REG_ENTRY_Y = 3'd1,
    REG_ENTRY_Z = 3'd2,
    REG_EXIT_X  = 3'd3,
    REG_EXIT_Y  = 3'd4,
    REG_EXIT_Z  = 3'd5
  } reg_idx_t;

  localparam logic [1:0] CASE_GENERAL   = 2'd0;
  localparam logic [1:0] CASE_OPPOSITE  = 2'd1;
  localparam logic [1:0] CASE_IDENTICAL = 2'd2;

  typedef struct packed {
    logic signed [VW-1:0] in_x;
    logic signed [VW-1:0] in_y;
    logic signed [VW-1:0] in_z;
  } in_t;

  typedef struct packed {
    logic signed [VW-1:0] out_x;
    logic signed [VW-1:0] out_y;
    logic signed [VW-1:0] out_z;
    logic [1:0]           case_taken;
  } out_t;

  // entry normal plus everything derived from both normals
  typedef struct packed {
    logic signed [CW-1:0] nx;
    logic signed [CW-1:0] ny;
    logic signed [CW-1:0] nz;
    logic signed [KW-1:0] kx;
    logic signed [KW-1:0] ky;
    logic signed [KW-1:0] kz;
    logic [1:0]           code;
    logic                 axis_y;
    logic [DW-1:0]        d;
  } geom_t;

  // one component entering the divider
  typedef struct packed {
    logic                    neg;
    logic                    use_q;
    logic signed [BASEW-1:0] base;
    logic [NUMW-1:0]         num;
  } lane_t;

  // one component inside the divider
  typedef struct packed {
    logic                    neg;
    logic                    use_q;
    logic signed [BASEW-1:0] base;
    logic [DW-1:0]           rem;
    logic [QW-1:0]           quo;
  } div_lane_t;

endpackage

[sv/vmpp_front.sv]
module vmpp_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  vmpp_pkg::in_t             in_data,
  input  vmpp_pkg::geom_t           geom,
  output logic                      out_vld,
  output vmpp_pkg::lane_t [2:0]     lanes
);
  import vmpp_pkg::*;

  logic [7:0]               vld_r;
  logic signed [VW-1:0]     vin [3];
  logic signed [CW-1:0]     n [3];
  logic signed [VW-1:0]     v1_r [3];
  logic signed [VW-1:0]     v2_r [3];
  logic signed [VW-1:0]     v3_r [3];
  logic signed [47:0]       p1_r [3];
  logic signed [49:0]       dsum;
  logic signed [DOTW-1:0]   dot2_r;
  logic signed [TW-1:0]     t3_r [3];
  logic signed [FW-1:0]     f4_r [3];
  logic signed [FW-1:0]     f5_r [3];
  logic signed [FW-1:0]     f6_r [3];
  logic signed [FW-1:0]     f7_r [3];
  logic signed [PFW-1:0]    pf5_r [6];
  logic signed [AW-1:0]     a6_r [3];
  logic signed [AW-1:0]     a7_r [3];
  logic signed [PAW-1:0]    pa7_r [6];
  logic signed [BW-1:0]     b8 [3];
  logic [BW-1:0]            mag8 [3];
  lane_t [2:0]              lanes_nxt;
  lane_t [2:0]              lanes_r;

  assign vin[0] = in_data.in_x;
  assign vin[1] = in_data.in_y;
  assign vin[2] = in_data.in_z;
  assign n[0]   = geom.nx;
  assign n[1]   = geom.ny;
  assign n[2]   = geom.nz;

  assign dsum = 50'(p1_r[0]) + 50'(p1_r[1]) + 50'(p1_r[2]) + 50'sd8192;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b8[i] = BW'((63'(pa7_r[2*i]) - 63'(pa7_r[2*i+1]) + 63'sd8192) >>> 14);
      mag8[i] = b8[i][BW-1] ? BW'(-b8[i]) : BW'(b8[i]);
      lanes_nxt[i].neg   = b8[i][BW-1];
      lanes_nxt[i].use_q = (geom.code == CASE_GENERAL);
      lanes_nxt[i].num   = NUMW'({mag8[i], 28'd0}) + NUMW'(geom.d >> 1);
      case (geom.code)
        CASE_GENERAL:  lanes_nxt[i].base = BASEW'(f7_r[i]) + BASEW'(a7_r[i]);
        CASE_OPPOSITE: begin
          // half turn: x axis flips y,z; y axis flips x,z
          if (i == 2 || (geom.axis_y ? (i == 0) : (i == 1))) begin
            lanes_nxt[i].base = -BASEW'(f7_r[i]);
          end else begin
            lanes_nxt[i].base = BASEW'(f7_r[i]);
          end
        end
        default:       lanes_nxt[i].base = BASEW'(f7_r[i]);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[6:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v1_r[i] <= vin[i];
        p1_r[i] <= 48'(vin[i]) * 48'(n[i]);
        v2_r[i] <= v1_r[i];
        v3_r[i] <= v2_r[i];
        t3_r[i] <= TW'(dot2_r) * TW'(n[i]);
        // round(2*t, 14) == round(t, 13)
        f4_r[i] <= FW'(v3_r[i]) - FW'((t3_r[i] + 52'sd4096) >>> 13);
        f5_r[i] <= f4_r[i];
        f6_r[i] <= f5_r[i];
        f7_r[i] <= f6_r[i];
        a6_r[i] <= AW'((59'(pf5_r[2*i]) - 59'(pf5_r[2*i+1]) + 59'sd8192) >>> 14);
        a7_r[i] <= a6_r[i];
      end
      dot2_r   <= DOTW'(dsum >>> 14);
      pf5_r[0] <= PFW'(geom.ky) * PFW'(f4_r[2]);
      pf5_r[1] <= PFW'(geom.kz) * PFW'(f4_r[1]);
      pf5_r[2] <= PFW'(geom.kz) * PFW'(f4_r[0]);
      pf5_r[3] <= PFW'(geom.kx) * PFW'(f4_r[2]);
      pf5_r[4] <= PFW'(geom.kx) * PFW'(f4_r[1]);
      pf5_r[5] <= PFW'(geom.ky) * PFW'(f4_r[0]);
      pa7_r[0] <= PAW'(geom.ky) * PAW'(a6_r[2]);
      pa7_r[1] <= PAW'(geom.kz) * PAW'(a6_r[1]);
      pa7_r[2] <= PAW'(geom.kz) * PAW'(a6_r[0]);
      pa7_r[3] <= PAW'(geom.kx) * PAW'(a6_r[2]);
      pa7_r[4] <= PAW'(geom.kx) * PAW'(a6_r[1]);
      pa7_r[5] <= PAW'(geom.ky) * PAW'(a6_r[0]);
      lanes_r  <= lanes_nxt;
    end
  end

  assign out_vld = vld_r[7];
  assign lanes   = lanes_r;

endmodule

[sv/vmpp_div.sv]
module vmpp_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  vmpp_pkg::lane_t [2:0]         lanes,
  input  logic [vmpp_pkg::DW-1:0]       d,
  output logic                          out_vld,
  output vmpp_pkg::div_lane_t [2:0]     res
);
  import vmpp_pkg::*;

  // restoring division, one quotient bit per stage, three components side by side
  logic [QW-1:0]       vld_r;
  div_lane_t [2:0]     stg_r [QW];
  div_lane_t [2:0]     src [QW];
  div_lane_t [2:0]     stg_nxt [QW];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      src[0][i].neg   = lanes[i].neg;
      src[0][i].use_q = lanes[i].use_q;
      src[0][i].base  = lanes[i].base;
      src[0][i].rem   = DW'(lanes[i].num[NUMW-1:QW]);
      src[0][i].quo   = lanes[i].num[QW-1:0];
    end
    for (int s = 1; s < QW; s++) begin
      src[s] = stg_r[s-1];
    end
  end

  always_comb begin
    logic [DW:0] sh;
    logic        ge;
    for (int s = 0; s < QW; s++) begin
      for (int i = 0; i < 3; i++) begin
        sh = {src[s][i].rem, src[s][i].quo[QW-1]};
        ge = (sh >= {1'b0, d});
        stg_nxt[s][i].neg   = src[s][i].neg;
        stg_nxt[s][i].use_q = src[s][i].use_q;
        stg_nxt[s][i].base  = src[s][i].base;
        stg_nxt[s][i].rem   = ge ? DW'(sh - {1'b0, d}) : DW'(sh);
        stg_nxt[s][i].quo   = {src[s][i].quo[QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < QW; s++) begin
        stg_r[s] <= stg_nxt[s];
      end
    end
  end

  assign out_vld = vld_r[QW-1];
  assign res     = stg_r[QW-1];

endmodule

[sv/vector_map_through_portal_pair.sv]
// Maps Q16.16 vectors through a pair of planes: reflection across the entry
// normal, then a rotation carrying the entry normal onto the exit normal.
// Channels: in_valid/in_ready/in_data carry one vector per transaction;
// out_valid/out_ready/out_data return one mapped vector and its case code per
// transaction, in order. cfg_valid/cfg_index/cfg_data write the six Q2.14
// normal components (indexes 0-5, others ignored); cfg_ready is always high.
// Pipeline: 65 register stages (8 arithmetic, 56 divider, output register).
// Throughput: one vector per cycle while in_ready is high. The divider, one
// quotient bit per stage, sets the depth.
// Reset (synchronous, rst_n low) clears all valid bits and loads both normals
// with (0, 0, 1.0). When out_ready is low the result holds in the output
// register; one more result lands in a skid register, after which in_ready
// drops and the whole pipeline holds until out_ready returns.
module vector_map_through_portal_pair (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  vmpp_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output vmpp_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [15:0]     cfg_data
);
  import vmpp_pkg::*;

  logic signed [CW-1:0]  nx_r, ny_r, nz_r, mx_r, my_r, mz_r;
  logic signed [CSW-1:0] cos_nxt;
  geom_t                 geom_nxt;
  geom_t                 geom_r;
  geom_t                 geom;
  logic                  en;
  logic                  front_vld;
  lane_t [2:0]           lanes;
  logic                  div_vld;
  div_lane_t [2:0]       res;
  out_t                  res_data;
  logic signed [SUMW-1:0] sum [3];
  logic signed [VW-1:0]  sat [3];
  out_t                  out_r, skid_r;
  logic                  out_valid_r, skid_valid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r <= '0;
      ny_r <= '0;
      nz_r <= 16'sd16384;
      mx_r <= '0;
      my_r <= '0;
      mz_r <= 16'sd16384;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENTRY_X: nx_r <= cfg_data;
        REG_ENTRY_Y: ny_r <= cfg_data;
        REG_ENTRY_Z: nz_r <= cfg_data;
        REG_EXIT_X:  mx_r <= cfg_data;
        REG_EXIT_Y:  my_r <= cfg_data;
        REG_EXIT_Z:  mz_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // derived from the normals; first used several stages after entry
  always_comb begin
    cos_nxt = CSW'(nx_r * mx_r) + CSW'(ny_r * my_r) + CSW'(nz_r * mz_r);
    geom_nxt = '0;
    geom_nxt.kx = KW'((34'(ny_r * mz_r) - 34'(nz_r * my_r) + 34'sd8192) >>> 14);
    geom_nxt.ky = KW'((34'(nz_r * mx_r) - 34'(nx_r * mz_r) + 34'sd8192) >>> 14);
    geom_nxt.kz = KW'((34'(nx_r * my_r) - 34'(ny_r * mx_r) + 34'sd8192) >>> 14);
    if (cos_nxt <= -COS_LIMIT) begin
      geom_nxt.code = CASE_OPPOSITE;
    end else if (cos_nxt >= COS_LIMIT) begin
      geom_nxt.code = CASE_IDENTICAL;
    end else begin
      geom_nxt.code = CASE_GENERAL;
    end
    geom_nxt.axis_y = (nx_r >= AXIS_LIMIT) || (nx_r <= -AXIS_LIMIT);
    geom_nxt.d      = DW'(ONE_Q28 + cos_nxt);
  end

  always_ff @(posedge clk) begin
    geom_r <= geom_nxt;
  end

  // entry normal goes in straight: stage one multiplies by it
  always_comb begin
    geom    = geom_r;
    geom.nx = nx_r;
    geom.ny = ny_r;
    geom.nz = nz_r;
  end

  assign en       = !skid_valid_r;
  assign in_ready = en;

  vmpp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .geom     (geom),
    .out_vld  (front_vld),
    .lanes    (lanes)
  );

  vmpp_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (front_vld),
    .lanes   (lanes),
    .d       (geom_r.d),
    .out_vld (div_vld),
    .res     (res)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = SUMW'(res[i].base);
      if (res[i].use_q) begin
        sum[i] = res[i].neg ? sum[i] - $signed(SUMW'(res[i].quo))
                            : sum[i] + $signed(SUMW'(res[i].quo));
      end
      if (sum[i] > SUMW'(32'sh7fffffff)) begin
        sat[i] = 32'sh7fffffff;
      end else if (sum[i] < SUMW'(-33'sh80000000)) begin
        sat[i] = 32'sh80000000;
      end else begin
        sat[i] = VW'(sum[i]);
      end
    end
    res_data.out_x      = sat[0];
    res_data.out_y      = sat[1];
    res_data.out_z      = sat[2];
    res_data.case_taken = geom_r.code;
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= div_vld;
      end
    end else if (!skid_valid_r && div_vld) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid_r) begin
      out_r <= skid_valid_r ? skid_r : res_data;
    end else if (!skid_valid_r) begin
      skid_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[sv/vmpp_checker.sv]
`include "vector_map_through_portal_pair_macros.svh"

module vmpp_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input vmpp_pkg::out_t out_data
);
  import vmpp_pkg::*;

  `VMPP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
  `VMPP_ASSERT_IMPLY(a_backpressure, !in_ready, out_valid, "input blocked with no result waiting")
  `VMPP_ASSERT_NEXT(a_drain_frees, out_valid && out_ready, in_ready, "input still blocked after a result left")
  `VMPP_ASSERT_IMPLY(a_case_code, out_valid, out_data.case_taken != 2'd3, "unused case code")

endmodule

bind vector_map_through_portal_pair vmpp_checker u_vmpp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
